@@ rtl/clpd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clpd_pkg
// Shared types and codes for the click / long-press detector.
// ----------------------------------------------------------------------------
package clpd_pkg;

    localparam int TIME_W   = 32;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int EVENT_W  = 3;
    localparam int COUNT_W  = 4;
    localparam int PHASE_W  = 3;

    localparam logic [CFG_W-1:0]     LONG_PRESS_RST = 16'd1000;
    localparam logic [CFG_W-1:0]     SHORT_RST      = 16'd300;
    localparam logic [COUNT_W-1:0]   REPEAT_CAP     = 4'd15;

    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT      = 1'd1;

    localparam logic [PHASE_W-1:0] PH_IDLE      = 3'd0;
    localparam logic [PHASE_W-1:0] PH_PRESSED   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_RELEASED  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_REPRESSED = 3'd3;
    localparam logic [PHASE_W-1:0] PH_LONG      = 3'd5;

    localparam logic [EVENT_W-1:0] EV_NONE       = 3'd0;
    localparam logic [EVENT_W-1:0] EV_DOWN       = 3'd1;
    localparam logic [EVENT_W-1:0] EV_UP         = 3'd2;
    localparam logic [EVENT_W-1:0] EV_SINGLE     = 3'd3;
    localparam logic [EVENT_W-1:0] EV_DOUBLE     = 3'd4;
    localparam logic [EVENT_W-1:0] EV_LONG_START = 3'd5;
    localparam logic [EVENT_W-1:0] EV_LONG_HOLD  = 3'd6;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [TIME_W-1:0]  edge_time;
        logic [COUNT_W-1:0] rpt_count;
    } press_state_t;

    typedef struct packed {
        logic [CFG_W-1:0] long_thresh;
        logic [CFG_W-1:0] click_window;
    } cfg_t;

endpackage

@@ rtl/clpd_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clpd_cfg_regs
// Timing window registers, written through the plain write port.
// ----------------------------------------------------------------------------
module clpd_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [clpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [clpd_pkg::CFG_W-1:0]      cfg_data,
    output clpd_pkg::cfg_t                  cfg
);

    clpd_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.long_thresh  <= clpd_pkg::LONG_PRESS_RST;
            cfg_reg.click_window <= clpd_pkg::SHORT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                clpd_pkg::CFG_LONG_PRESS: cfg_reg.long_thresh  <= cfg_data;
                clpd_pkg::CFG_SHORT:      cfg_reg.click_window <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/clpd_step_logic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clpd_step_logic
// Next-state and event decode of the press machine for one scan word.
// ----------------------------------------------------------------------------
module clpd_step_logic (
    input  clpd_pkg::press_state_t              cur,
    input  clpd_pkg::cfg_t                      cfg,
    input  logic                                held,
    input  logic [clpd_pkg::TIME_W-1:0]         now_ms,
    output clpd_pkg::press_state_t              nxt,
    output logic [clpd_pkg::EVENT_W-1:0]        event_code
);

    logic [clpd_pkg::TIME_W-1:0] elapsed;
    logic [clpd_pkg::TIME_W-1:0] long_lim;
    logic [clpd_pkg::TIME_W-1:0] short_lim;

    assign elapsed   = now_ms - cur.edge_time;
    assign long_lim  = {{(clpd_pkg::TIME_W-clpd_pkg::CFG_W){1'b0}}, cfg.long_thresh};
    assign short_lim = {{(clpd_pkg::TIME_W-clpd_pkg::CFG_W){1'b0}}, cfg.click_window};

    always_comb begin
        nxt        = cur;
        event_code = clpd_pkg::EV_NONE;
        unique case (cur.phase)
            clpd_pkg::PH_IDLE: begin
                if (held) begin
                    event_code    = clpd_pkg::EV_DOWN;
                    nxt.edge_time = now_ms;
                    nxt.rpt_count = clpd_pkg::COUNT_W'(1);
                    nxt.phase     = clpd_pkg::PH_PRESSED;
                end
            end
            clpd_pkg::PH_PRESSED: begin
                if (!held) begin
                    event_code    = clpd_pkg::EV_UP;
                    nxt.edge_time = now_ms;
                    nxt.phase     = clpd_pkg::PH_RELEASED;
                end else if (elapsed > long_lim) begin
                    event_code = clpd_pkg::EV_LONG_START;
                    nxt.phase  = clpd_pkg::PH_LONG;
                end
            end
            clpd_pkg::PH_RELEASED: begin
                if (held) begin
                    event_code = clpd_pkg::EV_DOWN;
                    if (cur.rpt_count != clpd_pkg::REPEAT_CAP) begin
                        nxt.rpt_count = cur.rpt_count + clpd_pkg::COUNT_W'(1);
                    end
                    nxt.edge_time = now_ms;
                    nxt.phase     = clpd_pkg::PH_REPRESSED;
                end else if (elapsed > short_lim) begin
                    if (cur.rpt_count == clpd_pkg::COUNT_W'(1)) begin
                        event_code = clpd_pkg::EV_SINGLE;
                    end else if (cur.rpt_count == clpd_pkg::COUNT_W'(2)) begin
                        event_code = clpd_pkg::EV_DOUBLE;
                    end
                    nxt.phase = clpd_pkg::PH_IDLE;
                end
            end
            clpd_pkg::PH_REPRESSED: begin
                if (!held) begin
                    event_code = clpd_pkg::EV_UP;
                    if (elapsed < short_lim) begin
                        nxt.edge_time = now_ms;
                        nxt.phase     = clpd_pkg::PH_RELEASED;
                    end else begin
                        nxt.phase = clpd_pkg::PH_IDLE;
                    end
                end else if (elapsed > short_lim) begin
                    nxt.phase = clpd_pkg::PH_PRESSED;
                end
            end
            clpd_pkg::PH_LONG: begin
                if (held) begin
                    event_code = clpd_pkg::EV_LONG_HOLD;
                end else begin
                    event_code = clpd_pkg::EV_UP;
                    nxt.phase  = clpd_pkg::PH_IDLE;
                end
            end
            default: begin
                nxt.phase = clpd_pkg::PH_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/click_long_press_detector_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// click_long_press_detector_core
// Per-tick press machine reporting down, up, click, double click and
// long-press events with a saturating repeat count.
// ----------------------------------------------------------------------------
//  channel   | direction | word
//  s_*       | in        | chord_held, now_ms
//  m_*       | out       | event_code, click_count
//  cfg_*     | in        | write-only: 0 long-press threshold, 1 click window
//
//  One word per cycle sustained while m_ready is high; s_ accept loads the
//  input register, then an advance loads the result register and raises m_valid.
//  The press state updates in the same cycle the result register loads.
//  m_ready low holds the result; one further word is buffered in the input
//  register before s_ready drops. Synchronous active-low reset, no init pass.
// ----------------------------------------------------------------------------
module click_long_press_detector_core (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_chord_held,
    input  logic [clpd_pkg::TIME_W-1:0]         s_now_ms,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [clpd_pkg::EVENT_W-1:0]        m_event_code,
    output logic [clpd_pkg::COUNT_W-1:0]        m_click_count,

    input  logic                                cfg_we,
    input  logic [clpd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [clpd_pkg::CFG_W-1:0]          cfg_data
);

    clpd_pkg::cfg_t              cfg;
    clpd_pkg::press_state_t      state_reg;
    clpd_pkg::press_state_t      state_next;
    logic [clpd_pkg::EVENT_W-1:0] event_next;

    logic                         in_valid_reg;
    logic                         in_held_reg;
    logic [clpd_pkg::TIME_W-1:0]  in_now_reg;

    logic                         out_valid_reg;
    logic [clpd_pkg::EVENT_W-1:0] out_event_reg;
    logic [clpd_pkg::COUNT_W-1:0] out_count_reg;

    logic advance;
    logic s_fire;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    clpd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    clpd_step_logic u_step (
        .cur        (state_reg),
        .cfg        (cfg),
        .held       (in_held_reg),
        .now_ms     (in_now_reg),
        .nxt        (state_next),
        .event_code (event_next)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_fire) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_held_reg <= s_chord_held;
            in_now_reg  <= s_now_ms;
        end
    end

    // press state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase     <= clpd_pkg::PH_IDLE;
            state_reg.edge_time <= '0;
            state_reg.rpt_count <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_event_reg <= event_next;
            out_count_reg <= state_next.rpt_count;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_event_code  = out_event_reg;
    assign m_click_count = out_count_reg;

    a_adv_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid && (m_event_code == $past(event_next)))
        else $error("result not loaded on advance");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("empty input register not ready");

    a_count_live: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.phase != clpd_pkg::PH_IDLE |-> state_reg.rpt_count != '0)
        else $error("active press with zero count");

    a_hold_from_long: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (event_next == clpd_pkg::EV_LONG_HOLD)
        |-> state_reg.phase == clpd_pkg::PH_LONG)
        else $error("long hold outside long press");

    a_state_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("press state moved without advance");

endmodule
